/* hw/rtl/sprtd_pkg.sv */
// shared types and constants for the sprite entry to tile draw block
package sprtd_pkg;

	localparam int IN_W  = 40;
	localparam int OUT_W = 40;
	localparam int IDX_W = 3;
	localparam int CFG_W = 64;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_COLOR_MASK     = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRIORITY_MASK  = 3'd1;
	localparam logic [IDX_W-1:0] REG_PRIORITY_VALUE = 3'd2;
	localparam logic [IDX_W-1:0] REG_SCREEN_FLIP    = 3'd3;
	localparam logic [IDX_W-1:0] REG_HEIGHT_TABLE   = 3'd4;

	// height classes
	localparam logic [1:0] HCLS_SINGLE = 2'd0;
	localparam logic [1:0] HCLS_DOUBLE = 2'd1;
	localparam logic [1:0] HCLS_QUAD   = 2'd2;

	localparam logic [9:0] SY_BASE      = 10'd369;
	localparam logic [9:0] SX_FLIP_BASE = 10'd496;
	localparam logic [9:0] SY_FLIP_BASE = 10'd242;
	localparam logic [9:0] DOUBLE_SHIFT = 10'd16;
	localparam logic [9:0] QUAD_SHIFT   = 10'd48;
	localparam logic [4:0] COLOR_RESET  = 5'h1f;

	// one classified sprite waiting for expansion
	typedef struct packed {
		logic [10:0] code;
		logic [4:0]  color;
		logic        flip_x;
		logic        flip_y;
		logic [9:0]  sx;
		logic [9:0]  sy;
		logic [1:0]  last_k;
	} sprite_ent_t;

endpackage

/* hw/rtl/sprtd_front.sv */
// front end: configuration registers, priority test and sprite classification
module sprtd_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sprtd_pkg::IDX_W-1:0]      cfg_idx,
	input  logic [sprtd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                             s_tvalid,
	input  logic [sprtd_pkg::IN_W-1:0]       s_tdata,
	output logic                             s_tready,
	output logic                             push,
	output sprtd_pkg::sprite_ent_t           push_ent,
	input  logic                             full
);

	logic [4:0]  color_mask_q;
	logic [7:0]  prio_mask_q;
	logic [7:0]  prio_value_q;
	logic        screen_flip_q;
	logic [63:0] height_q;

	logic [7:0]  attr;
	logic [8:0]  ypos;
	logic [8:0]  xpos;
	logic [10:0] code_raw;
	logic        pass;
	logic [1:0]  hcls;
	logic [9:0]  sy_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mask_q  <= sprtd_pkg::COLOR_RESET;
			prio_mask_q   <= '0;
			prio_value_q  <= '0;
			screen_flip_q <= 1'b0;
			height_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sprtd_pkg::REG_COLOR_MASK:     color_mask_q  <= cfg_data[4:0];
				sprtd_pkg::REG_PRIORITY_MASK:  prio_mask_q   <= cfg_data[7:0];
				sprtd_pkg::REG_PRIORITY_VALUE: prio_value_q  <= cfg_data[7:0];
				sprtd_pkg::REG_SCREEN_FLIP:    screen_flip_q <= cfg_data[0];
				sprtd_pkg::REG_HEIGHT_TABLE:   height_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign attr     = s_tdata[7:0];
	assign ypos     = {s_tdata[16], s_tdata[15:8]};
	assign code_raw = {s_tdata[27:25], s_tdata[24:17]};
	assign xpos     = {s_tdata[38], s_tdata[37:30]};

	assign pass     = (attr & prio_mask_q) == prio_value_q;
	assign hcls     = height_q[{code_raw[9:5], 1'b0} +: 2];
	assign sy_raw   = sprtd_pkg::SY_BASE - {1'b0, ypos};

	always_comb begin
		push_ent.color  = attr[4:0] & color_mask_q;
		push_ent.code   = code_raw;
		push_ent.sx     = {1'b0, xpos};
		push_ent.sy     = sy_raw;
		push_ent.last_k = hcls;
		// class three keeps four tiles but no alignment and no shift
		unique case (hcls)
			sprtd_pkg::HCLS_SINGLE: ;
			sprtd_pkg::HCLS_DOUBLE: begin
				push_ent.code = {code_raw[10:1], 1'b0};
				push_ent.sy   = sy_raw - sprtd_pkg::DOUBLE_SHIFT;
			end
			sprtd_pkg::HCLS_QUAD: begin
				push_ent.code   = {code_raw[10:2], 2'b00};
				push_ent.sy     = sy_raw - sprtd_pkg::QUAD_SHIFT;
				push_ent.last_k = 2'd3;
			end
			default: ;
		endcase
		push_ent.flip_x = s_tdata[28] ^ screen_flip_q;
		push_ent.flip_y = s_tdata[29] ^ screen_flip_q;
		if (screen_flip_q) begin
			push_ent.sx = sprtd_pkg::SX_FLIP_BASE - {1'b0, xpos};
			push_ent.sy = sprtd_pkg::SY_FLIP_BASE - {4'b0, push_ent.last_k, 4'b0} - push_ent.sy;
		end
	end

	assign s_tready = !full;
	// entries failing the priority test are taken and dropped
	assign push     = s_tvalid && !full && pass;

endmodule

/* hw/rtl/sprtd_queue.sv */
// small fifo of classified sprites between front and back
module sprtd_queue #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  sprtd_pkg::sprite_ent_t push_ent,
	output logic                   full,
	input  logic                   pop,
	output sprtd_pkg::sprite_ent_t head,
	output logic                   empty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

	sprtd_pkg::sprite_ent_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = count_q == '0;
	assign full  = count_q == DEPTH_CNT;

endmodule

/* hw/rtl/sprtd_back.sv */
// back end: expands one queued sprite into its tile words
module sprtd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sprtd_pkg::sprite_ent_t          head,
	input  logic                            empty,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sprtd_pkg::OUT_W-1:0]     m_tdata,
	output logic                            m_tlast
);

	logic [1:0]  cnt_q;
	logic [1:0]  k;
	logic        load;
	logic        is_last;
	logic [10:0] code_next;
	logic [9:0]  py_next;
	logic        valid_q;
	logic [sprtd_pkg::OUT_W-1:0] data_q;
	logic        last_q;

	// tiles go out from the bottom row up
	assign k         = head.last_k - cnt_q;
	assign is_last   = k == 2'd0;
	assign load      = !empty && (!valid_q || m_tready);
	assign pop       = load && is_last;
	assign code_next = head.code + {9'b0, head.flip_y ? cnt_q : k};
	assign py_next   = head.sy + {4'b0, k, 4'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q   <= is_last ? 2'd0 : cnt_q + 2'd1;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {2'b00, py_next, head.sx, head.flip_y, head.flip_x, head.color, code_next};
			last_q <= is_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> cnt_q <= head.last_k)
		else $error("tile counter beyond sprite height");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> cnt_q == 2'd0)
		else $error("tile counter running with no sprite queued");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_tvalid && m_tlast)
		else $error("sprite retired without a last tile word");

endmodule

/* hw/rtl/sprite_entry_to_tile_draws.sv */
// top level: sprite entry to tile draw command expander
// an accepted entry goes into the sprite queue; its tile words then pass the output register
// throughput: one tile word per cycle from the output register while the receiver is ready;
//   an entry gives one, two or four tile words by height class; a dropped entry gives none
// the input keeps accepting while the sprite queue has room
// reset: asynchronous active low, clears queue, counters and output valid, config to defaults
module sprite_entry_to_tile_draws #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sprtd_pkg::IDX_W-1:0]  cfg_idx,
	input  logic [sprtd_pkg::CFG_W-1:0]  cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// attribute_byte, y_low, y_high, code_low, code_high, mirror_x, mirror_y, x_low, x_high
	input  logic [sprtd_pkg::IN_W-1:0]   s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// tile_code, tile_color, draw_flip_x, draw_flip_y, pos_x, pos_y
	output logic [sprtd_pkg::OUT_W-1:0]  m_tdata,
	output logic                         m_tlast
);

	logic                   push;
	logic                   full;
	logic                   pop;
	logic                   empty;
	sprtd_pkg::sprite_ent_t push_ent;
	sprtd_pkg::sprite_ent_t head;

	sprtd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tready (s_tready),
		.push     (push),
		.push_ent (push_ent),
		.full     (full)
	);

	sprtd_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	sprtd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* sim/tb_sprite_entry_to_tile_draws.sv */
// self-checking testbench for the sprite entry to tile draw expander
`timescale 1ns / 100ps

module tb_sprite_entry_to_tile_draws;

	typedef logic [sprtd_pkg::CFG_W-1:0] cfg_word_t;

	localparam logic [sprtd_pkg::IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam int STALL_CYCLES = 300;
	localparam int TAIL_CYCLES  = 12;
	localparam int WATCHDOG_MAX = 2000;

	typedef struct {
		logic [10:0] code;
		logic [4:0]  color;
		logic        flip_x;
		logic        flip_y;
		logic [9:0]  pos_x;
		logic [9:0]  pos_y;
		logic        last;
	} tile_cmd_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [sprtd_pkg::IDX_W-1:0]   cfg_idx = '0;
	logic [sprtd_pkg::CFG_W-1:0]   cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [sprtd_pkg::IN_W-1:0]    s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [sprtd_pkg::OUT_W-1:0]   m_tdata;
	logic                          m_tlast;

	// register shadows
	logic [4:0]  sh_color;
	logic [7:0]  sh_pmask;
	logic [7:0]  sh_pval;
	logic        sh_flip;
	logic [63:0] sh_htab;

	logic [sprtd_pkg::IN_W-1:0] entry_q[$];
	tile_cmd_t       tile_q[$];
	int pushed = 0;
	int accepted = 0;
	int fail_count = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int stall_req = 0;
	int stall_seen = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	logic in_fire = 1'b0;

	sprite_entry_to_tile_draws DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [sprtd_pkg::IN_W-1:0] pack_entry(input logic [7:0] attr,
			input logic [8:0] y, input logic [10:0] code, input logic mx, input logic my,
			input logic [8:0] x);
		return {1'b0, x, my, mx, code, y, attr};
	endfunction

	// expands one accepted entry into the tile words it should produce
	function automatic void predict_tiles(input logic [sprtd_pkg::IN_W-1:0] w);
		logic [7:0] attr;
		logic [1:0] hcls;
		logic       fx;
		logic       fy;
		int         ypos;
		int         xpos;
		int         code_v;
		int         n;
		int         k;
		int         sx;
		int         sy;
		int         tc;
		int         py;
		tile_cmd_t  t;
		attr = w[7:0];
		ypos = int'(w[16:8]);
		code_v = int'(w[27:17]);
		fx = w[28];
		fy = w[29];
		xpos = int'(w[38:30]);
		if ((attr & sh_pmask) != sh_pval)
			return;
		sx = xpos;
		sy = 369 - ypos;
		hcls = sh_htab[2 * ((code_v >> 5) & 31) +: 2];
		n = int'(hcls);
		case (hcls)
			sprtd_pkg::HCLS_DOUBLE: begin
				code_v = code_v & ~1;
				sy = sy - 16;
			end
			sprtd_pkg::HCLS_QUAD: begin
				n = 3;
				code_v = code_v & ~3;
				sy = sy - 48;
			end
			default: begin
			end
		endcase
		if (sh_flip) begin
			sx = 496 - sx;
			sy = 242 - 16 * n - sy;
			fx = ~fx;
			fy = ~fy;
		end
		for (k = n; k >= 0; k--) begin
			tc = fy ? (code_v + n - k) : (code_v + k);
			py = sy + 16 * k;
			t.code = tc[10:0];
			t.color = attr[4:0] & sh_color;
			t.flip_x = fx;
			t.flip_y = fy;
			t.pos_x = sx[9:0];
			t.pos_y = py[9:0];
			t.last = (k == 0);
			tile_q.push_back(t);
		end
	endfunction

	// entry driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_fire) begin
			// word still waiting for acceptance
		end else if (entry_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
			s_tvalid <= 1'b1;
			s_tdata <= entry_q.pop_front();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// tile receiver, with a long hold-off on request
	always @(negedge clk) begin
		if (stall_seen != stall_req) begin
			stall_seen = stall_req;
			stall_left = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// register shadows, prediction and tile checking
	always @(posedge clk) begin
		tile_cmd_t exp_t;
		if (!arst_n) begin
			sh_color <= sprtd_pkg::COLOR_RESET;
			sh_pmask <= '0;
			sh_pval  <= '0;
			sh_flip  <= 1'b0;
			sh_htab  <= '0;
			in_fire  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					sprtd_pkg::REG_COLOR_MASK:     sh_color <= cfg_data[4:0];
					sprtd_pkg::REG_PRIORITY_MASK:  sh_pmask <= cfg_data[7:0];
					sprtd_pkg::REG_PRIORITY_VALUE: sh_pval <= cfg_data[7:0];
					sprtd_pkg::REG_SCREEN_FLIP:    sh_flip <= cfg_data[0];
					sprtd_pkg::REG_HEIGHT_TABLE:   sh_htab <= cfg_data;
					default: begin
					end
				endcase
			end
			in_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				accepted <= accepted + 1;
				predict_tiles(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (tile_q.size() == 0) begin
					$error("unexpected tile word %h", m_tdata);
					fail_count = fail_count + 1;
				end else begin
					exp_t = tile_q.pop_front();
					if (m_tdata[10:0] !== exp_t.code) begin
						$error("tile_code: expected %0d, got %0d", exp_t.code, m_tdata[10:0]);
						fail_count = fail_count + 1;
					end
					if (m_tdata[15:11] !== exp_t.color) begin
						$error("tile_color: expected %0d, got %0d", exp_t.color, m_tdata[15:11]);
						fail_count = fail_count + 1;
					end
					if (m_tdata[16] !== exp_t.flip_x) begin
						$error("draw_flip_x: expected %0d, got %0d", exp_t.flip_x, m_tdata[16]);
						fail_count = fail_count + 1;
					end
					if (m_tdata[17] !== exp_t.flip_y) begin
						$error("draw_flip_y: expected %0d, got %0d", exp_t.flip_y, m_tdata[17]);
						fail_count = fail_count + 1;
					end
					if (m_tdata[27:18] !== exp_t.pos_x) begin
						$error("pos_x: expected %0d, got %0d", $signed(exp_t.pos_x),
							$signed(m_tdata[27:18]));
						fail_count = fail_count + 1;
					end
					if (m_tdata[37:28] !== exp_t.pos_y) begin
						$error("pos_y: expected %0d, got %0d", $signed(exp_t.pos_y),
							$signed(m_tdata[37:28]));
						fail_count = fail_count + 1;
					end
					if (m_tlast !== exp_t.last) begin
						$error("last_tile: expected %0d, got %0d", exp_t.last, m_tlast);
						fail_count = fail_count + 1;
					end
				end
			end
		end
	end

	// watchdog: no word moving on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("sprite_entry_to_tile_draws regression: fail");
			$finish;
		end
	end

	task automatic send_entry(input logic [sprtd_pkg::IN_W-1:0] w);
		entry_q.push_back(w);
		pushed = pushed + 1;
	endtask

	// wait for every entry to be taken and every tile word to arrive
	task automatic drain;
		while (accepted != pushed || tile_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [sprtd_pkg::IDX_W-1:0] idx,
			input logic [sprtd_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_regs(input logic [4:0] cm, input logic [7:0] pm, input logic [7:0] pv,
			input logic sf, input logic [63:0] ht);
		drain();
		set_reg(sprtd_pkg::REG_COLOR_MASK, cfg_word_t'(cm));
		set_reg(sprtd_pkg::REG_PRIORITY_MASK, cfg_word_t'(pm));
		set_reg(sprtd_pkg::REG_PRIORITY_VALUE, cfg_word_t'(pv));
		set_reg(sprtd_pkg::REG_SCREEN_FLIP, cfg_word_t'(sf));
		set_reg(sprtd_pkg::REG_HEIGHT_TABLE, ht);
		repeat (2) @(posedge clk);
	endtask

	task automatic random_regs;
		logic [7:0] pm;
		pm = 8'($urandom) & 8'($urandom) & 8'($urandom);
		program_regs(5'($urandom), pm, 8'($urandom) & pm, 1'($urandom), {$urandom, $urandom});
	endtask

	// mostly entries that pass the priority test, the rest random attribute bytes
	task automatic random_entries(input int count);
		logic [7:0] attr;
		for (int i = 0; i < count; i++) begin
			attr = 8'($urandom);
			if ($urandom_range(0, 99) < 85)
				attr = (attr & ~sh_pmask) | sh_pval;
			send_entry(pack_entry(attr, 9'($urandom), 11'($urandom), 1'($urandom),
				1'($urandom), 9'($urandom)));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 21;
		recv_idle = 69;
		// reset settings: everything passes, single tiles
		send_entry(pack_entry(8'h00, 9'd0, 11'd0, 1'b0, 1'b0, 9'd0));
		send_entry(pack_entry(8'hff, 9'd511, 11'd2047, 1'b1, 1'b1, 9'd511));

		// height classes 0,1,2,3 repeating across the code groups
		program_regs(5'h0a, 8'h80, 8'h00, 1'b0, 64'he4e4_e4e4_e4e4_e4e4);
		set_reg(REG_UNMAPPED, '1);
		for (int g = 0; g < 4; g++) begin
			send_entry(pack_entry(8'h7f, 9'(g * 100), 11'(g * 32 + 3), g[0], 1'b0,
				9'(g * 120)));
			send_entry(pack_entry(8'h35, 9'(511 - g * 100), 11'(g * 32 + 3), ~g[0], 1'b1,
				9'(511 - g * 120)));
		end
		// code wrap in the tallest class
		send_entry(pack_entry(8'h1f, 9'd369, 11'd2047, 1'b0, 1'b0, 9'd0));
		send_entry(pack_entry(8'h0e, 9'd0, 11'd2046, 1'b1, 1'b1, 9'd511));
		// priority mismatch, nothing comes out
		send_entry(pack_entry(8'h80, 9'd10, 11'd5, 1'b0, 1'b0, 9'd10));

		drain();
		set_reg(sprtd_pkg::REG_SCREEN_FLIP, cfg_word_t'(1'b1));
		for (int g = 0; g < 4; g++)
			send_entry(pack_entry(8'h55, g[0] ? 9'd511 : 9'd0, 11'(g * 32 + 1), g[1], g[0],
				g[1] ? 9'd511 : 9'd0));

		random_regs();
		random_entries(20);
		program_regs(5'h00, 8'hff, 8'($urandom), 1'b0, '1);
		random_entries(20);

		send_idle = 69;
		recv_idle = 21;
		random_regs();
		random_entries(20);
		// sender holds back until every tile word is in
		drain();
		random_entries(20);

		send_idle = 0;
		recv_idle = 0;
		program_regs(5'h1f, 8'h00, 8'h00, 1'b1, 64'haaaa_aaaa_aaaa_aaaa);
		stall_req = stall_req + 1;
		random_entries(25);

		drain();
		if (fail_count == 0)
			$display("sprite_entry_to_tile_draws regression: pass");
		else
			$display("sprite_entry_to_tile_draws regression: fail");
		$finish;
	end

endmodule
